@@ sv/ssc_pkg.sv @@
// Shared types and constants of the segregating site classifier.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

  localparam int SYM_BITS    = 8;
  localparam int WEIGHT_BITS = 16;
  localparam int OUT_BITS    = 24;

  localparam logic [1:0] TALLY_MAX = 2'd2;

  typedef logic [1:0] tally_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]    sym;
    logic [WEIGHT_BITS-1:0] col_weight;
    logic                   last_in_column;
    logic                   restart;
  } in_item_t;

  typedef struct packed {
    logic                 column_segregating;
    logic                 column_informative;
    logic [OUT_BITS-1:0]  seg_total;
    logic [OUT_BITS-1:0]  informative_total;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [SYM_BITS-1:0] addr;
    tally_t              cnt;
  } tally_wr_t;

endpackage

`default_nettype wire

@@ sv/ssc_tally_ram.sv @@
// Per-symbol tally memory: one write port and one registered read port.
// Depends on ssc_pkg for the write request and tally types.
`timescale 1ns / 1ps
`default_nettype none

module ssc_tally_ram #(
  parameter int ALPHABET = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [ssc_pkg::SYM_BITS-1:0] rd_addr,
  output ssc_pkg::tally_t                   rd_cnt,
  input  wire ssc_pkg::tally_wr_t           wr
);

  localparam int SYM_W = $clog2(ALPHABET);

  ssc_pkg::tally_t mem [ALPHABET];
  ssc_pkg::tally_t rd_cnt_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[SYM_W-1:0]] <= wr.cnt;
    end
    if (rd_en) begin
      rd_cnt_r <= mem[rd_addr[SYM_W-1:0]];
    end
  end

  assign rd_cnt = rd_cnt_r;

endmodule

`default_nettype wire

@@ sv/ssc_column_unit.sv @@
// Update stage: tally read-modify-write with forwarding, column flags,
// saturating totals and the result register. Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_column_unit #(
  parameter int ALPHABET   = 256,
  parameter int TOTAL_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssc_pkg::in_item_t   in_item,
  output logic                     rd_en,
  input  wire ssc_pkg::tally_t     rd_cnt,
  output ssc_pkg::tally_wr_t       wr,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ssc_pkg::out_item_t       out_data
);

  localparam int SYM_W = $clog2(ALPHABET);
  localparam int EXT_W = (TOTAL_BITS > ssc_pkg::OUT_BITS) ? TOTAL_BITS : ssc_pkg::OUT_BITS;

  ssc_pkg::in_item_t                s1_item_r;
  logic                             s1_vld_r;
  logic [ALPHABET-1:0]              tally_vld_r;
  logic                             fwd_vld_r;
  logic [ssc_pkg::SYM_BITS-1:0]     fwd_addr_r;
  ssc_pkg::tally_t                  fwd_cnt_r;
  logic                             col_open_r;
  logic                             varies_r;
  logic [1:0]                       rep_r;
  logic [ssc_pkg::SYM_BITS-1:0]     first_r;
  logic [TOTAL_BITS-1:0]            seg_acc_r;
  logic [TOTAL_BITS-1:0]            inf_acc_r;
  logic                             out_vld_r;
  ssc_pkg::out_item_t               out_data_r;

  logic                             fire;
  logic                             accept;
  logic [SYM_W-1:0]                 idx;
  ssc_pkg::tally_t                  old_cnt;
  ssc_pkg::tally_t                  new_cnt;
  logic                             first_item;
  logic                             varies_nxt;
  logic [1:0]                       rep_base;
  logic [1:0]                       rep_nxt;
  logic                             seg;
  logic                             inf;
  logic [TOTAL_BITS-1:0]            seg_base;
  logic [TOTAL_BITS-1:0]            inf_base;
  logic [TOTAL_BITS:0]              seg_sum;
  logic [TOTAL_BITS:0]              inf_sum;
  logic [TOTAL_BITS-1:0]            seg_acc_nxt;
  logic [TOTAL_BITS-1:0]            inf_acc_nxt;
  logic [EXT_W-1:0]                 seg_ext;
  logic [EXT_W-1:0]                 inf_ext;

  assign fire     = s1_vld_r && (!s1_item_r.last_in_column || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || fire;
  assign accept   = in_valid && in_ready;
  assign rd_en    = accept;
  assign idx      = s1_item_r.sym[SYM_W-1:0];

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == s1_item_r.sym)) begin
      old_cnt = fwd_cnt_r;
    end else if (tally_vld_r[idx]) begin
      old_cnt = rd_cnt;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == ssc_pkg::TALLY_MAX) ? old_cnt : old_cnt + 2'd1;

    first_item = !col_open_r;
    varies_nxt = first_item ? 1'b0 : (varies_r || (s1_item_r.sym != first_r));
    rep_base   = first_item ? 2'd0 : rep_r;
    if ((new_cnt == ssc_pkg::TALLY_MAX) && (old_cnt != ssc_pkg::TALLY_MAX) &&
        (rep_base < ssc_pkg::TALLY_MAX)) begin
      rep_nxt = rep_base + 2'd1;
    end else begin
      rep_nxt = rep_base;
    end

    seg = s1_item_r.last_in_column && varies_nxt;
    inf = seg && (rep_nxt == ssc_pkg::TALLY_MAX);

    seg_base = s1_item_r.restart ? '0 : seg_acc_r;
    inf_base = s1_item_r.restart ? '0 : inf_acc_r;
    seg_sum  = {1'b0, seg_base} + (TOTAL_BITS + 1)'(s1_item_r.col_weight);
    inf_sum  = {1'b0, inf_base} + (TOTAL_BITS + 1)'(s1_item_r.col_weight);
    if (seg) begin
      seg_acc_nxt = seg_sum[TOTAL_BITS] ? '1 : seg_sum[TOTAL_BITS-1:0];
    end else begin
      seg_acc_nxt = seg_base;
    end
    if (inf) begin
      inf_acc_nxt = inf_sum[TOTAL_BITS] ? '1 : inf_sum[TOTAL_BITS-1:0];
    end else begin
      inf_acc_nxt = inf_base;
    end
    seg_ext = EXT_W'(seg_acc_nxt);
    inf_ext = EXT_W'(inf_acc_nxt);

    wr.en   = fire && !s1_item_r.last_in_column;
    wr.addr = s1_item_r.sym;
    wr.cnt  = new_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      tally_vld_r <= '0;
      fwd_vld_r   <= 1'b0;
      col_open_r  <= 1'b0;
      varies_r    <= 1'b0;
      rep_r       <= '0;
      first_r     <= '0;
      seg_acc_r   <= '0;
      inf_acc_r   <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (fire) begin
        s1_vld_r <= 1'b0;
      end

      if (fire) begin
        seg_acc_r <= seg_acc_nxt;
        inf_acc_r <= inf_acc_nxt;
        if (s1_item_r.last_in_column) begin
          tally_vld_r <= '0;
          fwd_vld_r   <= 1'b0;
          col_open_r  <= 1'b0;
          varies_r    <= 1'b0;
          rep_r       <= '0;
          first_r     <= '0;
        end else begin
          tally_vld_r[idx] <= 1'b1;
          fwd_vld_r        <= 1'b1;
          col_open_r       <= 1'b1;
          varies_r         <= varies_nxt;
          rep_r            <= rep_nxt;
          if (first_item) begin
            first_r <= s1_item_r.sym;
          end
        end
      end

      if (fire && s1_item_r.last_in_column) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      fwd_addr_r <= s1_item_r.sym;
      fwd_cnt_r  <= new_cnt;
    end
    if (fire && s1_item_r.last_in_column) begin
      out_data_r.column_segregating <= seg;
      out_data_r.column_informative <= inf;
      out_data_r.seg_total          <= seg_ext[ssc_pkg::OUT_BITS-1:0];
      out_data_r.informative_total  <= inf_ext[ssc_pkg::OUT_BITS-1:0];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_inf_implies_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_data_r.column_informative || out_data_r.column_segregating))
    else $error("informative result without segregating flag");

  a_rep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r != 2'd3)
    else $error("repeated symbol count exceeded its limit");

  a_column_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_item_r.last_in_column) |=> (!col_open_r && !fwd_vld_r && tally_vld_r == '0))
    else $error("column state not cleared after its last item");

  a_fwd_in_column: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_vld_r |-> col_open_r)
    else $error("forwarding active outside an open column");

  a_seg_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !s1_item_r.restart) |=> (seg_acc_r >= $past(seg_acc_r)))
    else $error("segregating total decreased without restart");

endmodule

`default_nettype wire

@@ sv/segregating_site_classifier.sv @@
// Top level of the segregating site classifier: symbol clamping, tally
// memory and update stage. Depends on ssc_pkg, ssc_tally_ram, ssc_column_unit.
//
// Usage: each request on the in_ channel carries one sequence's character of
// an alignment column, the column's weight, a last-in-column mark and a
// restart flag that clears both running totals before the request counts.
// Characters at or above ALPHABET count as ALPHABET-1.
// A column's last request yields one result on the out_ channel with the
// segregating and informative flags and both saturating totals; other
// requests yield none.
// Throughput: one request per cycle, but a column's last request waits while a
// result is pending; set by the single read-modify-write of the tally memory,
// with same-symbol forwarding between neighbors. The accepting edge loads the
// memory read and update stage; the update then loads the result register.
// Reset clears column state, totals and the per-entry valid bits at once;
// no clearing pass is needed. When out_ready is low with a result pending,
// requests inside a column still flow; a column's last request waits in the
// update stage and in_ready drops until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module segregating_site_classifier #(
  parameter int ALPHABET   = 256,
  parameter int TOTAL_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ssc_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ssc_pkg::out_item_t     out_data
);

  ssc_pkg::in_item_t            item_clamped;
  logic                         rd_en;
  ssc_pkg::tally_t              rd_cnt;
  ssc_pkg::tally_wr_t           wr;

  always_comb begin
    item_clamped = in_data;
    if ({1'b0, in_data.sym} >= (ssc_pkg::SYM_BITS + 1)'(ALPHABET)) begin
      item_clamped.sym = ssc_pkg::SYM_BITS'(ALPHABET - 1);
    end
  end

  ssc_tally_ram #(
    .ALPHABET (ALPHABET)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (item_clamped.sym),
    .rd_cnt  (rd_cnt),
    .wr      (wr)
  );

  ssc_column_unit #(
    .ALPHABET   (ALPHABET),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (item_clamped),
    .rd_en     (rd_en),
    .rd_cnt    (rd_cnt),
    .wr        (wr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
